@@ sv/ectlc_pkg.sv @@
package ectlc_pkg;

	localparam int unsigned EPOCH_W = 32;
	localparam int unsigned LOCAL_W = 33;
	localparam int unsigned DAYS_W = 17;
	localparam int unsigned SECS_W = 17;

	localparam logic [34:0] SECS_PER_HOUR = 35'd3600;
	localparam logic [32:0] SECS_PER_DAY = 33'd86400;
	localparam logic [16:0] DAYS_LIMIT = 17'd47482;
	localparam logic [4:0] OFFSET_RESET = 5'sd5;

	localparam logic [26:0] RECIP_675 = 27'd101806633;
	localparam logic [16:0] RECIP_1461 = 17'd91868;
	localparam logic [16:0] RECIP_7 = 17'd74899;
	localparam logic [17:0] RECIP_3600 = 18'd149131;
	localparam logic [12:0] RECIP_60 = 13'd4370;

	localparam logic [15:0] DAYS_FROM_1968 = 16'd731;
	localparam logic [15:0] EPOCH_WEEKDAY = 16'd4;
	localparam logic [11:0] BASE_YEAR = 12'd1968;

	typedef struct packed {
		logic valid;
		logic oor;
		logic [DAYS_W-1:0] days;
		logic [SECS_W-1:0] secs;
	} day_split_t;

	function automatic logic [8:0] month_start(input logic [3:0] idx, input logic leap);
		logic [8:0] base;
		case (idx)
			4'd0: base = 9'd0;
			4'd1: base = 9'd31;
			4'd2: base = 9'd59;
			4'd3: base = 9'd90;
			4'd4: base = 9'd120;
			4'd5: base = 9'd151;
			4'd6: base = 9'd181;
			4'd7: base = 9'd212;
			4'd8: base = 9'd243;
			4'd9: base = 9'd273;
			4'd10: base = 9'd304;
			4'd11: base = 9'd334;
			default: base = 9'd0;
		endcase
		if (leap && idx >= 4'd2) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

@@ sv/epoch_to_local_calendar_core.sv @@
// Converts an unsigned count of Unix epoch seconds into broken-down local time.
// A request is taken at each rising edge where start is high and busy is low.
// The block is fully pipelined, so busy stays low and a new request may be
// given in every cycle; the sustained rate is one request per clock.
// Each result appears on the field ports for one cycle with done high, and
// results leave in request order.
// The pipeline has seven register stages: offset add, reciprocal
// multiply for the day count, day and second split, the four-year cycle,
// weekday and hour multiplies, their remainders, year decode with the minute
// multiply, and the final month lookup that feeds the output registers.
// The user must write the local offset in whole hours through cfg_wr_en and
// cfg_wr_data only while no request is in flight; the block does not enforce it.
// A local time outside 1970 through 2099 gives out_of_range high and all
// other fields zero. The local offset resets to plus five hours.
// Reset clears every valid bit in the pipeline, so no result follows a reset
// for requests taken before it. The receiver cannot stall, and each result
// must be taken in the cycle in which done is high.
module epoch_to_local_calendar_core import ectlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic start,
	output logic busy,
	input logic [31:0] epoch_seconds,
	input logic cfg_wr_en,
	input logic [4:0] cfg_wr_data,
	output logic done,
	output logic [5:0] second,
	output logic [5:0] minute,
	output logic [4:0] hour,
	output logic [4:0] day_of_month,
	output logic [3:0] month,
	output logic [11:0] year,
	output logic [2:0] weekday,
	output logic [8:0] day_of_year,
	output logic out_of_range
);

	logic [4:0] offset_q;
	day_split_t split;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			offset_q <= OFFSET_RESET;
		end else if (cfg_wr_en) begin
			offset_q <= cfg_wr_data;
		end
	end

	assign busy = 1'b0;

	ectlc_day_split u_day_split (
		.clk (clk),
		.arst_n (arst_n),
		.in_valid (start && !busy),
		.epoch_seconds (epoch_seconds),
		.utc_offset_hours (offset_q),
		.split (split)
	);

	ectlc_field_calc u_field_calc (
		.clk (clk),
		.arst_n (arst_n),
		.split (split),
		.done (done),
		.second (second),
		.minute (minute),
		.hour (hour),
		.day_of_month (day_of_month),
		.month (month),
		.year (year),
		.weekday (weekday),
		.day_of_year (day_of_year),
		.out_of_range (out_of_range)
	);

endmodule

@@ sv/ectlc_day_split.sv @@
module ectlc_day_split import ectlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic [EPOCH_W-1:0] epoch_seconds,
	input logic [4:0] utc_offset_hours,
	output day_split_t split
);

	logic [34:0] local_c;
	logic valid_s1;
	logic neg_s1;
	logic [LOCAL_W-1:0] loc_s1;

	logic [52:0] prod_c;
	logic valid_s2;
	logic neg_s2;
	logic [LOCAL_W-1:0] loc_s2;
	logic [52:0] prod_s2;

	logic [DAYS_W-1:0] days_c;
	logic [32:0] day_secs_c;
	logic [32:0] secs_c;
	logic valid_s3;
	logic oor_s3;
	logic [DAYS_W-1:0] days_s3;
	logic [SECS_W-1:0] secs_s3;

	assign local_c = {3'b000, epoch_seconds}
		+ {{30{utc_offset_hours[4]}}, utc_offset_hours} * SECS_PER_HOUR;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		neg_s1 <= local_c[34];
		loc_s1 <= local_c[LOCAL_W-1:0];
	end

	// Dividing by 86400 is a shift by 7 followed by a reciprocal multiply for 675.
	assign prod_c = {27'd0, loc_s1[32:7]} * {26'd0, RECIP_675};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		neg_s2 <= neg_s1;
		loc_s2 <= loc_s1;
		prod_s2 <= prod_c;
	end

	assign days_c = prod_s2[52:36];
	assign day_secs_c = {16'd0, days_c} * SECS_PER_DAY;
	assign secs_c = loc_s2 - day_secs_c;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else begin
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		oor_s3 <= neg_s2 || (days_c >= DAYS_LIMIT);
		days_s3 <= days_c;
		secs_s3 <= secs_c[SECS_W-1:0];
	end

	assign split.valid = valid_s3;
	assign split.oor = oor_s3;
	assign split.days = days_s3;
	assign split.secs = secs_s3;

endmodule

@@ sv/ectlc_field_calc.sv @@
module ectlc_field_calc import ectlc_pkg::*; (
	input logic clk,
	input logic arst_n,
	input day_split_t split,
	output logic done,
	output logic [5:0] second,
	output logic [5:0] minute,
	output logic [4:0] hour,
	output logic [4:0] day_of_month,
	output logic [3:0] month,
	output logic [11:0] year,
	output logic [2:0] weekday,
	output logic [8:0] day_of_year,
	output logic out_of_range
);

	logic [15:0] dp_c;
	logic [15:0] wx_c;
	logic [32:0] cyc_prod_c;
	logic [32:0] wd_prod_c;
	logic [34:0] hr_prod_c;
	logic valid_s4;
	logic oor_s4;
	logic [15:0] dp_s4;
	logic [15:0] wx_s4;
	logic [SECS_W-1:0] secs_s4;
	logic [32:0] cyc_prod_s4;
	logic [32:0] wd_prod_s4;
	logic [34:0] hr_prod_s4;

	logic [5:0] cycle_c;
	logic [15:0] cyc_r_c;
	logic [13:0] wq_c;
	logic [15:0] wday_c;
	logic [4:0] hour_c;
	logic [SECS_W-1:0] remh_c;
	logic valid_s5;
	logic oor_s5;
	logic [5:0] cycle_s5;
	logic [10:0] r_s5;
	logic [2:0] wday_s5;
	logic [4:0] hour_s5;
	logic [11:0] remh_s5;

	logic [10:0] t_c;
	logic [1:0] yo_c;
	logic [10:0] yday_c;
	logic [24:0] min_prod_c;
	logic valid_s6;
	logic oor_s6;
	logic [11:0] year_s6;
	logic [8:0] yday_s6;
	logic leap_s6;
	logic [24:0] min_prod_s6;
	logic [11:0] remh_s6;
	logic [2:0] wday_s6;
	logic [4:0] hour_s6;

	logic [3:0] mon_idx_c;
	logic [8:0] mday_c;
	logic [5:0] minute_c;
	logic [11:0] second_c;
	logic valid_s7;
	logic oor_s7;
	logic [5:0] second_s7;
	logic [5:0] minute_s7;
	logic [4:0] hour_s7;
	logic [4:0] mday_s7;
	logic [3:0] month_s7;
	logic [11:0] year_s7;
	logic [2:0] wday_s7;
	logic [8:0] yday_s7;

	// Days are counted from 1968-01-01 so that every four-year cycle opens with its leap year.
	assign dp_c = split.days[15:0] + DAYS_FROM_1968;
	assign wx_c = split.days[15:0] + EPOCH_WEEKDAY;
	assign cyc_prod_c = {17'd0, dp_c} * {16'd0, RECIP_1461};
	assign wd_prod_c = {17'd0, wx_c} * {16'd0, RECIP_7};
	assign hr_prod_c = {18'd0, split.secs} * {17'd0, RECIP_3600};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else begin
			valid_s4 <= split.valid;
		end
	end

	always_ff @(posedge clk) begin
		oor_s4 <= split.oor;
		dp_s4 <= dp_c;
		wx_s4 <= wx_c;
		secs_s4 <= split.secs;
		cyc_prod_s4 <= cyc_prod_c;
		wd_prod_s4 <= wd_prod_c;
		hr_prod_s4 <= hr_prod_c;
	end

	assign cycle_c = cyc_prod_s4[32:27];
	assign cyc_r_c = dp_s4 - {10'd0, cycle_c} * 16'd1461;
	assign wq_c = wd_prod_s4[32:19];
	assign wday_c = wx_s4 - {2'd0, wq_c} * 16'd7;
	assign hour_c = hr_prod_s4[33:29];
	assign remh_c = secs_s4 - {12'd0, hour_c} * 17'd3600;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s5 <= 1'b0;
		end else begin
			valid_s5 <= valid_s4;
		end
	end

	always_ff @(posedge clk) begin
		oor_s5 <= oor_s4;
		cycle_s5 <= cycle_c;
		r_s5 <= cyc_r_c[10:0];
		wday_s5 <= wday_c[2:0];
		hour_s5 <= hour_c;
		remh_s5 <= remh_c[11:0];
	end

	assign t_c = r_s5 - 11'd366;

	always_comb begin
		if (r_s5 < 11'd366) begin
			yo_c = 2'd0;
			yday_c = r_s5;
		end else if (t_c < 11'd365) begin
			yo_c = 2'd1;
			yday_c = t_c;
		end else if (t_c < 11'd730) begin
			yo_c = 2'd2;
			yday_c = t_c - 11'd365;
		end else begin
			yo_c = 2'd3;
			yday_c = t_c - 11'd730;
		end
	end

	assign min_prod_c = {13'd0, remh_s5} * {12'd0, RECIP_60};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s6 <= 1'b0;
		end else begin
			valid_s6 <= valid_s5;
		end
	end

	always_ff @(posedge clk) begin
		oor_s6 <= oor_s5;
		year_s6 <= BASE_YEAR + {4'd0, cycle_s5, 2'b00} + {10'd0, yo_c};
		yday_s6 <= yday_c[8:0];
		leap_s6 <= (yo_c == 2'd0);
		min_prod_s6 <= min_prod_c;
		remh_s6 <= remh_s5;
		wday_s6 <= wday_s5;
		hour_s6 <= hour_s5;
	end

	always_comb begin
		mon_idx_c = 4'd0;
		for (int i = 1; i < 12; i++) begin
			if (yday_s6 >= month_start(4'(i), leap_s6)) begin
				mon_idx_c = 4'(i);
			end
		end
	end

	assign mday_c = yday_s6 - month_start(mon_idx_c, leap_s6) + 9'd1;
	assign minute_c = min_prod_s6[23:18];
	assign second_c = remh_s6 - {6'd0, minute_c} * 12'd60;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s7 <= 1'b0;
		end else begin
			valid_s7 <= valid_s6;
		end
	end

	always_ff @(posedge clk) begin
		oor_s7 <= oor_s6;
		if (oor_s6) begin
			second_s7 <= '0;
			minute_s7 <= '0;
			hour_s7 <= '0;
			mday_s7 <= '0;
			month_s7 <= '0;
			year_s7 <= '0;
			wday_s7 <= '0;
			yday_s7 <= '0;
		end else begin
			second_s7 <= second_c[5:0];
			minute_s7 <= minute_c;
			hour_s7 <= hour_s6;
			mday_s7 <= mday_c[4:0];
			month_s7 <= mon_idx_c + 4'd1;
			year_s7 <= year_s6;
			wday_s7 <= wday_s6;
			yday_s7 <= yday_s6;
		end
	end

	assign done = valid_s7;
	assign second = second_s7;
	assign minute = minute_s7;
	assign hour = hour_s7;
	assign day_of_month = mday_s7;
	assign month = month_s7;
	assign year = year_s7;
	assign weekday = wday_s7;
	assign day_of_year = yday_s7;
	assign out_of_range = oor_s7;

endmodule

@@ sv/ectlc_checker.sv @@
module ectlc_checker (
	input logic clk,
	input logic arst_n,
	input logic start,
	input logic busy,
	input logic done,
	input logic [5:0] second,
	input logic [5:0] minute,
	input logic [4:0] hour,
	input logic [4:0] day_of_month,
	input logic [3:0] month,
	input logic [11:0] year,
	input logic [2:0] weekday,
	input logic [8:0] day_of_year,
	input logic out_of_range
);

	a_latency: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |-> ##7 done)
		else $error("request did not produce a result after seven cycles");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		done |-> $past(start && !busy, 7))
		else $error("result without a matching request");

	a_oor_zero: assert property (@(posedge clk) disable iff (!arst_n)
		done && out_of_range |-> second == 6'd0 && minute == 6'd0 && hour == 5'd0
			&& day_of_month == 5'd0 && month == 4'd0 && year == 12'd0
			&& weekday == 3'd0 && day_of_year == 9'd0)
		else $error("out of range result carries nonzero fields");

	a_fields_legal: assert property (@(posedge clk) disable iff (!arst_n)
		done && !out_of_range |-> second <= 6'd59 && minute <= 6'd59 && hour <= 5'd23
			&& day_of_month >= 5'd1 && month >= 4'd1 && month <= 4'd12
			&& year >= 12'd1970 && year <= 12'd2099 && weekday <= 3'd6
			&& day_of_year <= 9'd365)
		else $error("calendar field outside its legal range");

endmodule

bind epoch_to_local_calendar_core ectlc_checker u_ectlc_checker (
	.clk (clk),
	.arst_n (arst_n),
	.start (start),
	.busy (busy),
	.done (done),
	.second (second),
	.minute (minute),
	.hour (hour),
	.day_of_month (day_of_month),
	.month (month),
	.year (year),
	.weekday (weekday),
	.day_of_year (day_of_year),
	.out_of_range (out_of_range)
);

@@ tb/tb_epoch_to_local_calendar_core.sv @@
`timescale 1ns / 1ps

module tb_epoch_to_local_calendar_core;
	import ectlc_pkg::*;

	localparam int unsigned STALL_LIMIT = 2000;
	localparam int unsigned RANDOM_PER_PHASE = 68;

	typedef struct packed {
		logic [5:0] second;
		logic [5:0] minute;
		logic [4:0] hour;
		logic [4:0] day_of_month;
		logic [3:0] month;
		logic [11:0] year;
		logic [2:0] weekday;
		logic [8:0] day_of_year;
		logic out_of_range;
	} calendar_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic start = 1'b0;
	logic busy;
	logic [31:0] epoch_seconds = '0;
	logic cfg_wr_en = 1'b0;
	logic [4:0] cfg_wr_data = '0;
	logic done;
	logic [5:0] second;
	logic [5:0] minute;
	logic [4:0] hour;
	logic [4:0] day_of_month;
	logic [3:0] month;
	logic [11:0] year;
	logic [2:0] weekday;
	logic [8:0] day_of_year;
	logic out_of_range;

	logic [31:0] pending_epochs[$];
	calendar_t expected_calendar[$];
	logic signed [4:0] offset_model = OFFSET_RESET;
	bit sender_gaps = 1'b1;
	int unsigned errors = 0;
	int unsigned requests_taken = 0;
	int unsigned results_seen = 0;
	int unsigned out_of_range_seen = 0;
	int unsigned offsets_used = 0;
	int unsigned quiet_cycles = 0;

	epoch_to_local_calendar_core uut (
		.clk(clk),
		.arst_n(arst_n),
		.start(start),
		.busy(busy),
		.epoch_seconds(epoch_seconds),
		.cfg_wr_en(cfg_wr_en),
		.cfg_wr_data(cfg_wr_data),
		.done(done),
		.second(second),
		.minute(minute),
		.hour(hour),
		.day_of_month(day_of_month),
		.month(month),
		.year(year),
		.weekday(weekday),
		.day_of_year(day_of_year),
		.out_of_range(out_of_range)
	);

	initial begin
		forever #2 clk = ~clk;
	end

	function automatic int unsigned year_length(input int unsigned y);
		return (y % 4 == 0) ? 366 : 365;
	endfunction

	function automatic longint days_to_year(input int unsigned y);
		longint total;
		total = 0;
		for (int unsigned k = 1970; k < y; k++) begin
			total += year_length(k);
		end
		return total;
	endfunction

	function automatic longint local_instant(input int unsigned y, input int yday,
			input int h, input int m, input int s);
		return (days_to_year(y) + yday) * 86400 + h * 3600 + m * 60 + s;
	endfunction

	function automatic calendar_t calendar_of(input logic [31:0] epoch,
			input logic signed [4:0] off);
		int unsigned month_days[12] = '{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};
		calendar_t c;
		longint loc_secs;
		longint days;
		longint secs;
		longint rem;
		int unsigned y;
		int unsigned m;
		int unsigned len;
		c = '0;
		loc_secs = longint'(epoch) + longint'(off) * 3600;
		if (loc_secs < 0) begin
			c.out_of_range = 1'b1;
			return c;
		end
		days = loc_secs / 86400;
		secs = loc_secs % 86400;
		if (days >= days_to_year(2100)) begin
			c.out_of_range = 1'b1;
			return c;
		end
		rem = days;
		y = 1970;
		while (rem >= year_length(y)) begin
			rem -= year_length(y);
			y++;
		end
		c.day_of_year = rem[8:0];
		m = 0;
		forever begin
			len = month_days[m];
			if (m == 1 && y % 4 == 0) begin
				len = 29;
			end
			if (rem < len || m == 11) begin
				break;
			end
			rem -= len;
			m++;
		end
		c.second = 6'(secs % 60);
		c.minute = 6'((secs / 60) % 60);
		c.hour = 5'(secs / 3600);
		c.day_of_month = 5'(rem + 1);
		c.month = 4'(m + 1);
		c.year = 12'(y);
		c.weekday = 3'((days + 4) % 7);
		return c;
	endfunction

	function automatic bit push_local(input longint loc_secs);
		longint e;
		e = loc_secs - longint'(offset_model) * 3600;
		if (e < 0 || e > 64'hFFFF_FFFF) begin
			return 1'b0;
		end
		pending_epochs.push_back(e[31:0]);
		return 1'b1;
	endfunction

	function automatic longint near_boundary();
		int unsigned y;
		longint anchor;
		case ($urandom_range(4))
			0: anchor = 0;
			1: anchor = days_to_year(2100) * 86400;
			2: anchor = days_to_year($urandom_range(1971, 2099)) * 86400;
			3: begin
				y = 4 * $urandom_range(493, 524);
				anchor = local_instant(y, 59, 0, 0, 0);
			end
			default: anchor = local_instant($urandom_range(1970, 2099), 364, 0, 0, 0);
		endcase
		return anchor + longint'($urandom_range(7200)) - 3600;
	endfunction

	task automatic queue_random(input int unsigned count);
		int unsigned pick;
		for (int unsigned n = 0; n < count; n++) begin
			pick = $urandom_range(99);
			if (pick < 35) begin
				pending_epochs.push_back($urandom);
			end else if (pick < 70) begin
				if (!push_local(near_boundary())) begin
					pending_epochs.push_back($urandom);
				end
			end else begin
				if (!push_local(longint'($urandom) % (days_to_year(2100) * 86400))) begin
					pending_epochs.push_back($urandom);
				end
			end
		end
	endtask

	task automatic wait_drained();
		do begin
			@(negedge clk);
		end while (pending_epochs.size() > 0 || start || expected_calendar.size() > 0);
	endtask

	task automatic check_field(input string name, input int unsigned want,
			input int unsigned got);
		if (want != got) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			errors++;
		end
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (start && !busy) begin
				expected_calendar.push_back(calendar_of(epoch_seconds, offset_model));
				requests_taken++;
			end
			if (!(start && busy)) begin
				if (pending_epochs.size() > 0 && !(sender_gaps && $urandom_range(99) < 26)) begin
					start <= 1'b1;
					epoch_seconds <= pending_epochs.pop_front();
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	always @(posedge clk) begin
		calendar_t want;
		if (arst_n && done) begin
			results_seen++;
			if (out_of_range) begin
				out_of_range_seen++;
			end
			if (expected_calendar.size() == 0) begin
				$error("result with no request outstanding");
				errors++;
			end else begin
				want = expected_calendar.pop_front();
				check_field("second", want.second, second);
				check_field("minute", want.minute, minute);
				check_field("hour", want.hour, hour);
				check_field("day_of_month", want.day_of_month, day_of_month);
				check_field("month", want.month, month);
				check_field("year", want.year, year);
				check_field("weekday", want.weekday, weekday);
				check_field("day_of_year", want.day_of_year, day_of_year);
				check_field("out_of_range", want.out_of_range, out_of_range);
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n) begin
			if ((start && !busy) || done) begin
				quiet_cycles <= 0;
			end else if (quiet_cycles >= STALL_LIMIT) begin
				$display("Timeout: no request or result for %0d cycles.", STALL_LIMIT);
				$display("DONE: errors detected");
				$finish;
			end else begin
				quiet_cycles <= quiet_cycles + 1;
			end
		end
	end

	initial begin
		int phase_offsets[8] = '{5, -16, 15, -12, 14, 0, -1, 99};
		int unsigned next_offset;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		for (int p = 0; p < 8; p++) begin
			if (p > 0) begin
				wait_drained();
				next_offset = (phase_offsets[p] == 99) ? $urandom_range(31) : phase_offsets[p];
				@(posedge clk);
				cfg_wr_en <= 1'b1;
				cfg_wr_data <= next_offset[4:0];
				@(posedge clk);
				cfg_wr_en <= 1'b0;
				offset_model = next_offset[4:0];
			end
			offsets_used++;
			sender_gaps = (p != 3);
			if (p == 0) begin
				pending_epochs.push_back(32'h0000_0000);
				pending_epochs.push_back(32'hFFFF_FFFF);
				pending_epochs.push_back(32'h8000_0000);
				pending_epochs.push_back(32'h7FFF_FFFF);
				void'(push_local(local_instant(1972, 59, 0, 0, 0)));
				void'(push_local(local_instant(2000, 59, 12, 34, 56)));
				void'(push_local(local_instant(2000, 365, 23, 59, 59)));
				void'(push_local(local_instant(2001, 0, 0, 0, 0)));
				void'(push_local(local_instant(2096, 365, 23, 59, 59)));
				void'(push_local(local_instant(2099, 58, 23, 59, 59)));
				void'(push_local(days_to_year(2100) * 86400 - 1));
				void'(push_local(days_to_year(2100) * 86400));
			end else if (p == 1) begin
				void'(push_local(-1));
				void'(push_local(0));
				pending_epochs.push_back(32'h0000_0000);
			end
			queue_random(RANDOM_PER_PHASE);
		end

		wait_drained();
		repeat (20) @(posedge clk);
		$display("Converted %0d requests under %0d offset settings, including extremes.",
			requests_taken, offsets_used);
		$display("Checked %0d results, %0d of them out of range.", results_seen,
			out_of_range_seen);
		if (errors == 0) begin
			$display("DONE: 0 errors");
		end else begin
			$display("DONE: errors detected");
		end
		$finish;
	end

endmodule

@@ files.f @@
sv/ectlc_pkg.sv
sv/ectlc_day_split.sv
sv/ectlc_field_calc.sv
sv/epoch_to_local_calendar_core.sv
sv/ectlc_checker.sv
tb/tb_epoch_to_local_calendar_core.sv
